[rtl/msa_pkg.sv]
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants, field widths and codes for the multi-channel averager.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int CHANNELS = 5;
    localparam int WINDOW   = 8;

    // Fixed field widths.
    localparam int CH_W    = 3;
    localparam int TEMP_W  = 16;
    localparam int STAT_W  = 2;
    localparam int ERR_W   = 16;
    localparam int FILL_W  = 7;
    localparam int CFG_IDX_W = 1;

    // Widths that follow from the window depth and channel count.
    localparam int SUM_W   = TEMP_W + $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CHI_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ITER_W  = $clog2(SUM_W + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'd1;

    // Reset values of the limits.
    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RESET  = -16'sd2016;
    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RESET = 16'sd2960;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_VALID        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DISCONNECTED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

    localparam logic [ERR_W-1:0] ERR_MAX = '1;

endpackage

[rtl/msa_if.sv]
// ----------------------------------------------------------------------------
// msa_if
// Valid/ready channels for samples in and averaged results out.
// ----------------------------------------------------------------------------
interface msa_in_if;
    import msa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          channel;
    logic signed [TEMP_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

interface msa_out_if;
    import msa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          out_channel;
    logic [STAT_W-1:0]        status;
    logic signed [TEMP_W-1:0] held_value;
    logic signed [TEMP_W-1:0] average;
    logic [ERR_W-1:0]         error_total;
    logic [FILL_W-1:0]        fill;

    modport source (output valid, output out_channel, output status, output held_value,
                    output average, output error_total, output fill, input ready);
    modport sink (input valid, input out_channel, input status, input held_value,
                  input average, input error_total, input fill, output ready);
endinterface

[rtl/multi_channel_sensor_averager.sv]
// ----------------------------------------------------------------------------
// multi_channel_sensor_averager
// Per-channel limit check, error count and windowed moving average.
// ----------------------------------------------------------------------------
// A valid sample goes through the window read, the sum update, the bit-serial
// divide of the window sum and the output state before its result word is loaded.
// A rejected sample skips the divide and goes from the update to the output state.
// One sample is in work at a time; the next is taken the cycle after the
// result is loaded into the output register. A bad channel is dropped at once.
// Reset clears all channel state and restores the default limits.
module multi_channel_sensor_averager (
    input  logic                          clk,
    input  logic                          rst_n,
    msa_in_if.sink                        samples,
    msa_out_if.source                     results,
    input  logic                          cfg_we,
    input  logic [msa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msa_pkg::TEMP_W-1:0]    cfg_data
);
    import msa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic signed [TEMP_W-1:0] low_limit_reg;
    logic signed [TEMP_W-1:0] high_limit_reg;

    // Per-channel state.
    logic signed [TEMP_W-1:0] last_good_reg [CHANNELS];
    logic signed [SUM_W-1:0]  sum_reg       [CHANNELS];
    logic [CNT_W-1:0]         count_reg     [CHANNELS];
    logic [SLOT_W-1:0]        slot_reg      [CHANNELS];
    logic [ERR_W-1:0]         reject_reg    [CHANNELS];
    logic signed [TEMP_W-1:0] mean_reg      [CHANNELS];

    logic signed [TEMP_W-1:0] win_mem [DEPTH];
    logic signed [TEMP_W-1:0] rd_reg;

    // Current item.
    logic [CH_W-1:0]          ch_reg;
    logic signed [TEMP_W-1:0] sample_reg;
    logic [STAT_W-1:0]        status_reg;
    logic                     neg_reg;

    logic [CHI_W-1:0]         ci;
    logic [ADDR_W-1:0]        addr;
    logic                     accept;
    logic                     ch_ok;
    logic [STAT_W-1:0]        status_in;
    logic                     full;
    logic signed [SUM_W-1:0]  sum_new;
    logic [SUM_W-1:0]         dividend;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_W-1:0]         quotient;
    logic [SUM_W-1:0]         quot_signed;
    logic                     out_free;

    // Output register.
    logic                     out_valid_reg;
    logic [CH_W-1:0]          out_channel_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic signed [TEMP_W-1:0] out_held_reg;
    logic signed [TEMP_W-1:0] out_avg_reg;
    logic [ERR_W-1:0]         out_err_reg;
    logic [FILL_W-1:0]        out_fill_reg;

    assign ci     = CHI_W'(ch_reg);
    assign addr   = ADDR_W'(ci) * ADDR_W'(WINDOW) + ADDR_W'(slot_reg[ci]);
    assign accept = samples.valid && samples.ready;
    assign ch_ok  = int'(samples.channel) < CHANNELS;
    assign full   = count_reg[ci] >= CNT_W'(WINDOW);
    assign out_free = !out_valid_reg || results.ready;
    assign div_start = (state_reg == S_START);

    // The disconnected test wins when the limits are crossed.
    always_comb
    begin
        if (samples.sample < low_limit_reg)
            status_in = STATUS_DISCONNECTED;
        else if (samples.sample >= high_limit_reg)
            status_in = STATUS_OUT_OF_RANGE;
        else
            status_in = STATUS_VALID;
    end

    always_comb
    begin
        if (full)
            sum_new = sum_reg[ci] - SUM_W'(rd_reg) + SUM_W'(sample_reg);
        else
            sum_new = sum_reg[ci] + SUM_W'(sample_reg);
    end

    assign dividend    = sum_reg[ci][SUM_W-1] ? SUM_W'(-sum_reg[ci]) : SUM_W'(sum_reg[ci]);
    assign quot_signed = neg_reg ? (~quotient + 1'b1) : quotient;

    msa_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg[ci]),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && ch_ok)
                    state_next = S_READ;
            end
            S_READ:  state_next = S_UPD;
            S_UPD:   state_next = (status_reg == STATUS_VALID) ? S_START : S_OUT;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            low_limit_reg  <= LOW_LIMIT_RESET;
            high_limit_reg <= HIGH_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_good_reg[i] <= '0;
                sum_reg[i]       <= '0;
                count_reg[i]     <= '0;
                slot_reg[i]      <= '0;
                reject_reg[i]    <= '0;
                mean_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                    REG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_UPD)
            begin
                if (status_reg != STATUS_VALID)
                begin
                    if (reject_reg[ci] != ERR_MAX)
                        reject_reg[ci] <= reject_reg[ci] + 1'b1;
                end
                else
                begin
                    sum_reg[ci]       <= sum_new;
                    last_good_reg[ci] <= sample_reg;
                    if (!full)
                        count_reg[ci] <= count_reg[ci] + 1'b1;
                    if (slot_reg[ci] == SLOT_W'(WINDOW - 1))
                        slot_reg[ci] <= '0;
                    else
                        slot_reg[ci] <= slot_reg[ci] + 1'b1;
                end
            end

            if (state_reg == S_DIV && div_done)
                mean_reg[ci] <= quot_signed[TEMP_W-1:0];

            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Item capture, window memory and output payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            ch_reg     <= samples.channel;
            sample_reg <= samples.sample;
            status_reg <= status_in;
        end
        if (state_reg == S_READ)
            rd_reg <= win_mem[addr];
        if (state_reg == S_UPD && status_reg == STATUS_VALID)
            win_mem[addr] <= sample_reg;
        if (state_reg == S_START)
            neg_reg <= sum_reg[ci][SUM_W-1];
        if (state_reg == S_OUT && out_free)
        begin
            out_channel_reg <= ch_reg;
            out_status_reg  <= status_reg;
            out_held_reg    <= last_good_reg[ci];
            out_avg_reg     <= mean_reg[ci];
            out_err_reg     <= reject_reg[ci];
            out_fill_reg    <= FILL_W'(count_reg[ci]);
        end
    end

    assign samples.ready       = (state_reg == S_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.status      = out_status_reg;
    assign results.held_value  = out_held_reg;
    assign results.average     = out_avg_reg;
    assign results.error_total = out_err_reg;
    assign results.fill        = out_fill_reg;

endmodule

[rtl/msa_serial_div.sv]
// ----------------------------------------------------------------------------
// msa_serial_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msa_serial_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [msa_pkg::SUM_W-1:0] dividend,
    input  logic [msa_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [msa_pkg::SUM_W-1:0] quotient
);
    import msa_pkg::*;

    logic [SUM_W-1:0]  shift_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CNT_W:0]    trial;
    logic              fits;
    logic [CNT_W:0]    diff;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign trial = {rem_reg, shift_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (iter_reg == ITER_W'(SUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (iter_reg == ITER_W'(SUM_W - 1))
                    busy_reg <= 1'b0;
                iter_reg <= iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[SUM_W-2:0], fits};
            rem_reg   <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule
